FILE: rtl/spp_pkg.sv
package spp_pkg;

    localparam int SPAN_MAX    = 4096;
    localparam int SPAN_BITS   = $clog2(SPAN_MAX);
    localparam int BASE_LIMIT  = 65536;
    localparam int BASE_BITS   = $clog2(BASE_LIMIT);
    localparam int VALUE_BITS  = 32;
    localparam int PROD_BITS   = 30;

    localparam logic [PROD_BITS-1:0] PRODUCT_MOD = 30'd1000000007;

endpackage

FILE: rtl/segmented_prime_product_mod.sv
// Prime product over a range, modulo 1000000007, by a segmented sieve.
//
// Command channel: present i_low_bound and i_high_bound with start high;
// the transfer happens at the rising edge where start is high and busy is
// low. The result appears on o_prime_product and o_range_error for exactly
// one cycle, marked by o_result_valid; the receiver takes it at the end of
// that cycle and cannot stall the block. One query runs at a time.
// A rejected range (high below low, or span above SPAN_MAX) answers in the
// cycle right after the transfer, without going busy.
// A good query runs sequentially through one bit memory of base primes
// (BASE_LIMIT entries) and one segment bit memory (SPAN_MAX entries):
//   a bit-serial square root, a base fill of entries up to top, a check
//   of each base candidate up to sqrt(top) with one crossing write per
//   multiple, a segment fill over the span, a check of each candidate up
//   to top with a divider for the first multiple of each base prime and
//   one crossing write per multiple, then a read of each entry with a
//   bit-serial modular multiply per surviving prime. Wide queries near
//   2^32 run longest; the per-prime divider and the multiply dominate.
// Reset returns to idle and sets the running product to one; the memories
// are not cleared, every entry is written before a query reads it.
module segmented_prime_product_mod
    import spp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_low_bound,
    input  logic [VALUE_BITS-1:0] i_high_bound,
    output logic                  o_result_valid,
    output logic [PROD_BITS-1:0]  o_prime_product,
    output logic                  o_range_error
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_BFILL, S_BRD, S_BCHK, S_BX, S_SFILL,
        S_CRD, S_CCHK, S_CDIV, S_CST, S_CX, S_PRD, S_PCHK, S_PMUL
    } t_state;

    t_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [SPAN_BITS-1:0]  r_diff, n_diff;
    logic [BASE_BITS:0]    r_root, n_root;
    logic [BASE_BITS-1:0]  r_top, n_top;
    logic [BASE_BITS:0]    r_i, n_i;
    logic [VALUE_BITS:0]   r_k, n_k;
    logic [5:0]            r_cnt, n_cnt;
    logic [BASE_BITS:0]    r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_sq, n_sq;
    logic [PROD_BITS-1:0]  r_prod, n_prod, r_acc, n_acc;
    logic [VALUE_BITS:0]   r_n, n_n;
    logic [SPAN_BITS:0]    r_sk, n_sk;
    logic                  r_valid, n_valid;
    logic                  r_err, n_err;

    // memory ports
    logic                 base_we, base_wd, r_base_q;
    logic [BASE_BITS-1:0] base_wa, base_ra;
    logic                 seg_we, seg_wd, r_seg_q;
    logic [SPAN_BITS-1:0] seg_wa, seg_ra;
    logic                 mem_base [BASE_LIMIT];
    logic                 mem_seg  [SPAN_MAX];

    // datapath temporaries
    logic [BASE_BITS:0]       sq_t;
    logic [2*BASE_BITS+1:0]   sq_tt;
    logic [BASE_BITS:0]       rem_sh;
    logic [VALUE_BITS:0]      first_mul;
    logic [PROD_BITS:0]       mul_t1, mul_t2;
    logic [VALUE_BITS-1:0]    span_diff;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_diff  = r_diff;
        n_root  = r_root;
        n_top   = r_top;
        n_i     = r_i;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_sq    = r_sq;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_n     = r_n;
        n_sk    = r_sk;
        n_valid = 1'b0;
        n_err   = r_err;
        base_we = 1'b0;
        base_wa = r_i[BASE_BITS-1:0];
        base_wd = 1'b0;
        base_ra = r_i[BASE_BITS-1:0];
        seg_we  = 1'b0;
        seg_wa  = r_sk[SPAN_BITS-1:0];
        seg_wd  = 1'b0;
        seg_ra  = r_sk[SPAN_BITS-1:0];

        sq_t      = r_root | ((BASE_BITS+1)'(1) << r_cnt);
        sq_tt     = sq_t * sq_t;
        rem_sh    = {r_rem[BASE_BITS-1:0], r_lo[r_cnt[4:0]]};
        first_mul = {1'b0, r_lo} + ((r_rem != '0) ? (VALUE_BITS+1)'(r_i - r_rem) : '0);
        mul_t1    = {r_acc, 1'b0};
        if (mul_t1 >= {1'b0, PRODUCT_MOD}) mul_t1 = mul_t1 - {1'b0, PRODUCT_MOD};
        mul_t2    = mul_t1 + (r_n[r_cnt] ? {1'b0, r_prod} : '0);
        if (mul_t2 >= {1'b0, PRODUCT_MOD}) mul_t2 = mul_t2 - {1'b0, PRODUCT_MOD};
        span_diff = i_high_bound - i_low_bound;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_prod = PROD_BITS'(1);
                    if (i_high_bound < i_low_bound || span_diff >= VALUE_BITS'(SPAN_MAX)) begin
                        // reject at once, stay idle
                        n_valid = 1'b1;
                        n_err   = 1'b1;
                    end else begin
                        n_lo    = i_low_bound;
                        n_hi    = i_high_bound;
                        n_diff  = span_diff[SPAN_BITS-1:0];
                        n_root  = '0;
                        n_cnt   = 6'(BASE_BITS);
                        n_err   = 1'b0;
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                if ({2'b00, r_hi} >= sq_tt) n_root = sq_t;
                if (r_cnt == '0) begin
                    if (((r_hi >= sq_tt[VALUE_BITS-1:0]) && (sq_tt[2*BASE_BITS+1:VALUE_BITS] == '0)
                         ? sq_t : r_root) > (BASE_BITS+1)'(BASE_LIMIT-1))
                        n_top = BASE_BITS'(BASE_LIMIT-1);
                    else
                        n_top = ((r_hi >= sq_tt[VALUE_BITS-1:0])
                                 && (sq_tt[2*BASE_BITS+1:VALUE_BITS] == '0))
                                ? sq_t[BASE_BITS-1:0] : r_root[BASE_BITS-1:0];
                    n_i     = '0;
                    n_state = S_BFILL;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_BFILL: begin
                base_we = 1'b1;
                base_wd = (r_i >= (BASE_BITS+1)'(2));
                if (r_i[BASE_BITS-1:0] == r_top) begin
                    n_i     = (BASE_BITS+1)'(2);
                    n_state = S_BRD;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_BRD: begin
                if (r_i * r_i > (2*BASE_BITS+2)'(r_top)) begin
                    n_sk    = '0;
                    n_state = S_SFILL;
                end else begin
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                if (r_base_q) begin
                    n_k     = (VALUE_BITS+1)'(r_i * r_i);
                    n_state = S_BX;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_BRD;
                end
            end
            S_BX: begin
                if (r_k <= (VALUE_BITS+1)'(r_top)) begin
                    base_we = 1'b1;
                    base_wa = r_k[BASE_BITS-1:0];
                    n_k     = r_k + (VALUE_BITS+1)'(r_i);
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_BRD;
                end
            end
            S_SFILL: begin
                seg_we = 1'b1;
                seg_wd = ({1'b0, r_lo} + (VALUE_BITS+1)'(r_sk)) >= (VALUE_BITS+1)'(2);
                if (r_sk[SPAN_BITS-1:0] == r_diff) begin
                    n_i     = (BASE_BITS+1)'(2);
                    n_state = S_CRD;
                end else begin
                    n_sk = r_sk + 1'b1;
                end
            end
            S_CRD: begin
                if (r_i > (BASE_BITS+1)'(r_top)) begin
                    n_sk    = '0;
                    n_state = S_PRD;
                end else begin
                    n_state = S_CCHK;
                end
            end
            S_CCHK: begin
                if (r_base_q) begin
                    n_sq    = r_i[BASE_BITS-1:0] * r_i[BASE_BITS-1:0];
                    n_rem   = '0;
                    n_cnt   = 6'(VALUE_BITS-1);
                    n_state = S_CDIV;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CDIV: begin
                // restoring division, one bit of low bound a cycle
                n_rem = (rem_sh >= r_i) ? rem_sh - r_i : rem_sh;
                if (r_cnt == '0) n_state = S_CST;
                else n_cnt = r_cnt - 6'd1;
            end
            S_CST: begin
                n_k     = (first_mul < {1'b0, r_sq}) ? {1'b0, r_sq} : first_mul;
                n_state = S_CX;
            end
            S_CX: begin
                if (r_k <= {1'b0, r_hi}) begin
                    seg_we = 1'b1;
                    seg_wa = SPAN_BITS'(r_k - {1'b0, r_lo});
                    n_k    = r_k + (VALUE_BITS+1)'(r_i);
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_PRD: begin
                if (r_sk > (SPAN_BITS+1)'(r_diff)) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (r_seg_q) begin
                    n_n     = {1'b0, r_lo} + (VALUE_BITS+1)'(r_sk);
                    n_acc   = '0;
                    n_cnt   = 6'(VALUE_BITS);
                    n_state = S_PMUL;
                end else begin
                    n_sk    = r_sk + 1'b1;
                    n_state = S_PRD;
                end
            end
            S_PMUL: begin
                // double and add, one bit of the factor a cycle
                n_acc = mul_t2[PROD_BITS-1:0];
                if (r_cnt == '0) begin
                    n_prod  = mul_t2[PROD_BITS-1:0];
                    n_sk    = r_sk + 1'b1;
                    n_state = S_PRD;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_err   <= 1'b0;
            r_prod  <= PROD_BITS'(1);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_err   <= n_err;
            r_prod  <= n_prod;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_diff <= n_diff;
        r_root <= n_root;
        r_top  <= n_top;
        r_i    <= n_i;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_sq   <= n_sq;
        r_acc  <= n_acc;
        r_n    <= n_n;
        r_sk   <= n_sk;
    end

    // base prime bits
    always_ff @(posedge i_clk) begin
        if (base_we) mem_base[base_wa] <= base_wd;
        r_base_q <= mem_base[base_ra];
    end

    // segment bits
    always_ff @(posedge i_clk) begin
        if (seg_we) mem_seg[seg_wa] <= seg_wd;
        r_seg_q <= mem_seg[seg_ra];
    end

    assign o_result_valid  = r_valid;
    assign o_prime_product = r_prod;
    assign o_range_error   = r_err;

`ifndef ASSERT_OFF
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy) else $error("result while busy");
    a_err_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_range_error |-> o_prime_product == PROD_BITS'(1))
        else $error("rejected range without product one");
    a_prod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_prime_product < PRODUCT_MOD) else $error("product not reduced");
    a_busy_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_result_valid) else $error("transfer lost");
`endif

endmodule
